// File: sv/jsu_pkg.sv
// shared types, character codes and utf-8 helpers for the json string unescaper
// used by jsu_front, jsu_fifo, jsu_back and json_string_unescape_utf8_unit
`default_nettype none

package jsu_pkg;

  // segment list built per input byte
  localparam int MaxSegs  = 8;
  localparam int SegIdxW  = 3;
  localparam int SegCntW  = 4;

  // queue between front and back
  localparam int QDepth   = 4;
  localparam int QPtrW    = 2;
  localparam int QCntW    = 3;

  // configuration
  localparam logic [1:0]  ADDR_CAP     = 2'd0;
  localparam logic [15:0] CAP_RESET    = 16'hFFFF;

  // characters
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_LN     = 8'h6E;
  localparam logic [7:0] CH_LR     = 8'h72;
  localparam logic [7:0] CH_LT     = 8'h74;
  localparam logic [7:0] CH_LU     = 8'h75;
  localparam logic [7:0] CH_DIG0   = 8'h30;
  localparam logic [7:0] CH_DIG9   = 8'h39;
  localparam logic [7:0] CH_UPA    = 8'h41;
  localparam logic [7:0] CH_UPF    = 8'h46;
  localparam logic [7:0] CH_LOA    = 8'h61;
  localparam logic [7:0] CH_LOF    = 8'h66;

  localparam logic [7:0] CTL_BACKSP = 8'h08;
  localparam logic [7:0] CTL_FORMFD = 8'h0C;
  localparam logic [7:0] CTL_NEWLN  = 8'h0A;
  localparam logic [7:0] CTL_CRET   = 8'h0D;
  localparam logic [7:0] CTL_TAB    = 8'h09;

  // surrogate tags: top six bits of a 16-bit code unit
  localparam logic [5:0]  SUR_HIGH_TAG = 6'b110110;
  localparam logic [5:0]  SUR_LOW_TAG  = 6'b110111;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;

  typedef enum logic [5:0] {
    PH_IDLE    = 6'b000001,
    PH_BSLASH  = 6'b000010,
    PH_HEX     = 6'b000100,
    PH_WAIT_BS = 6'b001000,
    PH_WAIT_U  = 6'b010000,
    PH_LOW_HEX = 6'b100000
  } phase_t;

  // one output sequence: up to four bytes written whole or not at all,
  // or the terminator that closes a body
  typedef struct packed {
    logic            term;
    logic [2:0]      len;
    logic [3:0][7:0] data;
  } seg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic seg_t lit_seg(input logic [7:0] b);
    seg_t s;
    s      = '0;
    s.len  = 3'd1;
    s.data[0] = b;
    return s;
  endfunction

  function automatic seg_t term_seg();
    seg_t s;
    s      = '0;
    s.term = 1'b1;
    return s;
  endfunction

  function automatic seg_t encode_cp(input logic [20:0] cp);
    seg_t s;
    s = '0;
    if (cp == 21'd0) begin
      // nul goes out as the overlong pair
      s.len     = 3'd2;
      s.data[0] = 8'hC0;
      s.data[1] = 8'h80;
    end else if (cp < 21'h80) begin
      s.len     = 3'd1;
      s.data[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      s.len     = 3'd2;
      s.data[0] = {3'b110, cp[10:6]};
      s.data[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      s.len     = 3'd3;
      s.data[0] = {4'b1110, cp[15:12]};
      s.data[1] = {2'b10, cp[11:6]};
      s.data[2] = {2'b10, cp[5:0]};
    end else begin
      s.len     = 3'd4;
      s.data[0] = {5'b11110, cp[20:18]};
      s.data[1] = {2'b10, cp[17:12]};
      s.data[2] = {2'b10, cp[11:6]};
      s.data[3] = {2'b10, cp[5:0]};
    end
    return s;
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [7:0] d;
    d = '0;
    if (b >= CH_DIG0 && b <= CH_DIG9) begin
      d = b - CH_DIG0;
      return {1'b1, d[3:0]};
    end else if (b >= CH_UPA && b <= CH_UPF) begin
      d = b - CH_UPA + 8'd10;
      return {1'b1, d[3:0]};
    end else if (b >= CH_LOA && b <= CH_LOF) begin
      d = b - CH_LOA + 8'd10;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

`default_nettype wire

// File: sv/jsu_front.sv
// front end: escape state machine that turns each input byte into a short
// list of output sequences and pushes one per cycle while the queue has room; uses jsu_pkg
`default_nettype none

module jsu_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_byte,
  input  wire logic              body_end,
  output logic                   q_push,
  output jsu_pkg::seg_t          q_wdata,
  input  wire jsu_pkg::fifo_stat_t q_stat
);

  jsu_pkg::phase_t phase, phase_next, ph_f, simple_ph;
  logic [15:0] acc, acc_next, acc_shift;
  logic [9:0]  hs, hs_next;
  logic [1:0]  dc, dc_next;
  logic [3:0][7:0] chars, chars_next;
  logic [4:0]  hv;
  logic        simple;

  jsu_pkg::seg_t segs [jsu_pkg::MaxSegs];
  logic [jsu_pkg::SegCntW-1:0] n;

  jsu_pkg::seg_t pend [jsu_pkg::MaxSegs];
  logic [jsu_pkg::SegCntW-1:0] pcnt;

  logic accept;

  always_comb begin
    ph_f       = phase;
    acc_next   = acc;
    hs_next    = hs;
    dc_next    = dc;
    chars_next = chars;
    simple     = 1'b0;
    simple_ph  = jsu_pkg::PH_IDLE;
    n          = '0;
    for (int i = 0; i < jsu_pkg::MaxSegs; i++) segs[i] = '0;
    hv         = jsu_pkg::hex_value(in_byte);
    acc_shift  = {acc[11:0], hv[3:0]};

    unique case (phase)
      jsu_pkg::PH_IDLE, jsu_pkg::PH_BSLASH: begin
        simple    = 1'b1;
        simple_ph = phase;
      end
      jsu_pkg::PH_HEX, jsu_pkg::PH_LOW_HEX: begin
        if (!hv[4]) begin
          // broken \u: pending high half, then the escape as literal text
          if (phase == jsu_pkg::PH_LOW_HEX) begin
            segs[n[jsu_pkg::SegIdxW-1:0]] =
              jsu_pkg::encode_cp({5'd0, jsu_pkg::SUR_HIGH_TAG, hs});
            n = n + 4'd1;
          end
          segs[n[jsu_pkg::SegIdxW-1:0]] = jsu_pkg::lit_seg(jsu_pkg::CH_BSLASH);
          n = n + 4'd1;
          segs[n[jsu_pkg::SegIdxW-1:0]] = jsu_pkg::lit_seg(jsu_pkg::CH_LU);
          n = n + 4'd1;
          for (int i = 0; i < 4; i++) begin
            if (i < int'(dc)) begin
              segs[n[jsu_pkg::SegIdxW-1:0]] = jsu_pkg::lit_seg(chars[i]);
              n = n + 4'd1;
            end
          end
          dc_next   = 2'd0;
          simple    = 1'b1;
          simple_ph = jsu_pkg::PH_IDLE;
        end else begin
          acc_next = acc_shift;
          if (dc == 2'd3) begin
            dc_next = 2'd0;
            if (phase == jsu_pkg::PH_LOW_HEX &&
                acc_shift[15:10] == jsu_pkg::SUR_LOW_TAG) begin
              segs[n[jsu_pkg::SegIdxW-1:0]] =
                jsu_pkg::encode_cp(jsu_pkg::SUPP_BASE + {1'b0, hs, acc_shift[9:0]});
              n    = n + 4'd1;
              ph_f = jsu_pkg::PH_IDLE;
            end else begin
              if (phase == jsu_pkg::PH_LOW_HEX) begin
                segs[n[jsu_pkg::SegIdxW-1:0]] =
                  jsu_pkg::encode_cp({5'd0, jsu_pkg::SUR_HIGH_TAG, hs});
                n = n + 4'd1;
              end
              if (acc_shift[15:10] == jsu_pkg::SUR_HIGH_TAG) begin
                hs_next = acc_shift[9:0];
                ph_f    = jsu_pkg::PH_WAIT_BS;
              end else begin
                segs[n[jsu_pkg::SegIdxW-1:0]] = jsu_pkg::encode_cp({5'd0, acc_shift});
                n    = n + 4'd1;
                ph_f = jsu_pkg::PH_IDLE;
              end
            end
          end else begin
            chars_next[dc] = in_byte;
            dc_next        = dc + 2'd1;
          end
        end
      end
      jsu_pkg::PH_WAIT_BS: begin
        if (in_byte == jsu_pkg::CH_BSLASH) begin
          ph_f = jsu_pkg::PH_WAIT_U;
        end else begin
          segs[n[jsu_pkg::SegIdxW-1:0]] =
            jsu_pkg::encode_cp({5'd0, jsu_pkg::SUR_HIGH_TAG, hs});
          n         = n + 4'd1;
          simple    = 1'b1;
          simple_ph = jsu_pkg::PH_IDLE;
        end
      end
      jsu_pkg::PH_WAIT_U: begin
        if (in_byte == jsu_pkg::CH_LU) begin
          ph_f     = jsu_pkg::PH_LOW_HEX;
          dc_next  = 2'd0;
          acc_next = 16'd0;
        end else begin
          // lone high half, then the byte is read as an escape letter
          segs[n[jsu_pkg::SegIdxW-1:0]] =
            jsu_pkg::encode_cp({5'd0, jsu_pkg::SUR_HIGH_TAG, hs});
          n         = n + 4'd1;
          simple    = 1'b1;
          simple_ph = jsu_pkg::PH_BSLASH;
        end
      end
      default: ph_f = jsu_pkg::PH_IDLE;
    endcase

    // plain text and escape letters, also for a byte handed back for re-reading
    if (simple) begin
      if (simple_ph == jsu_pkg::PH_BSLASH) begin
        ph_f = jsu_pkg::PH_IDLE;
        unique case (in_byte)
          jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: begin
            segs[n[jsu_pkg::SegIdxW-1:0]] = jsu_pkg::lit_seg(in_byte);
            n = n + 4'd1;
          end
          jsu_pkg::CH_LB: begin
            segs[n[jsu_pkg::SegIdxW-1:0]] = jsu_pkg::lit_seg(jsu_pkg::CTL_BACKSP);
            n = n + 4'd1;
          end
          jsu_pkg::CH_LF: begin
            segs[n[jsu_pkg::SegIdxW-1:0]] = jsu_pkg::lit_seg(jsu_pkg::CTL_FORMFD);
            n = n + 4'd1;
          end
          jsu_pkg::CH_LN: begin
            segs[n[jsu_pkg::SegIdxW-1:0]] = jsu_pkg::lit_seg(jsu_pkg::CTL_NEWLN);
            n = n + 4'd1;
          end
          jsu_pkg::CH_LR: begin
            segs[n[jsu_pkg::SegIdxW-1:0]] = jsu_pkg::lit_seg(jsu_pkg::CTL_CRET);
            n = n + 4'd1;
          end
          jsu_pkg::CH_LT: begin
            segs[n[jsu_pkg::SegIdxW-1:0]] = jsu_pkg::lit_seg(jsu_pkg::CTL_TAB);
            n = n + 4'd1;
          end
          jsu_pkg::CH_LU: begin
            ph_f     = jsu_pkg::PH_HEX;
            dc_next  = 2'd0;
            acc_next = 16'd0;
          end
          default: begin
            segs[n[jsu_pkg::SegIdxW-1:0]] = jsu_pkg::lit_seg(jsu_pkg::CH_BSLASH);
            n = n + 4'd1;
            segs[n[jsu_pkg::SegIdxW-1:0]] = jsu_pkg::lit_seg(in_byte);
            n = n + 4'd1;
          end
        endcase
      end else if (in_byte == jsu_pkg::CH_BSLASH) begin
        ph_f = jsu_pkg::PH_BSLASH;
      end else begin
        ph_f = jsu_pkg::PH_IDLE;
        segs[n[jsu_pkg::SegIdxW-1:0]] = jsu_pkg::lit_seg(in_byte);
        n = n + 4'd1;
      end
    end

    phase_next = ph_f;
    if (body_end) begin
      // close out whatever escape is still open, then the terminator
      if (ph_f == jsu_pkg::PH_WAIT_BS || ph_f == jsu_pkg::PH_WAIT_U ||
          ph_f == jsu_pkg::PH_LOW_HEX) begin
        segs[n[jsu_pkg::SegIdxW-1:0]] =
          jsu_pkg::encode_cp({5'd0, jsu_pkg::SUR_HIGH_TAG, hs_next});
        n = n + 4'd1;
      end
      if (ph_f == jsu_pkg::PH_BSLASH || ph_f == jsu_pkg::PH_WAIT_U ||
          ph_f == jsu_pkg::PH_HEX || ph_f == jsu_pkg::PH_LOW_HEX) begin
        segs[n[jsu_pkg::SegIdxW-1:0]] = jsu_pkg::lit_seg(jsu_pkg::CH_BSLASH);
        n = n + 4'd1;
      end
      if (ph_f == jsu_pkg::PH_HEX || ph_f == jsu_pkg::PH_LOW_HEX) begin
        segs[n[jsu_pkg::SegIdxW-1:0]] = jsu_pkg::lit_seg(jsu_pkg::CH_LU);
        n = n + 4'd1;
        for (int i = 0; i < 4; i++) begin
          if (i < int'(dc_next)) begin
            segs[n[jsu_pkg::SegIdxW-1:0]] = jsu_pkg::lit_seg(chars_next[i]);
            n = n + 4'd1;
          end
        end
      end
      segs[n[jsu_pkg::SegIdxW-1:0]] = jsu_pkg::term_seg();
      n = n + 4'd1;
      phase_next = jsu_pkg::PH_IDLE;
      dc_next    = 2'd0;
    end
  end

  // pending list drains one sequence per cycle from its head while the queue has room
  assign q_push   = (pcnt != '0) && !q_stat.full;
  assign q_wdata  = pend[0];
  assign in_stall = (pcnt > 4'd1) || ((pcnt == 4'd1) && q_stat.full);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= jsu_pkg::PH_IDLE;
      dc    <= 2'd0;
      pcnt  <= '0;
    end else begin
      if (accept) begin
        phase <= phase_next;
        dc    <= dc_next;
        pcnt  <= n;
      end else if (q_push) begin
        pcnt  <= pcnt - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      acc   <= acc_next;
      hs    <= hs_next;
      chars <= chars_next;
      for (int i = 0; i < jsu_pkg::MaxSegs; i++) pend[i] <= segs[i];
    end else if (q_push) begin
      for (int i = 0; i < jsu_pkg::MaxSegs - 1; i++) pend[i] <= pend[i+1];
    end
  end

endmodule

`default_nettype wire

// File: sv/jsu_fifo.sv
// short queue of output sequences between front and back
// uses jsu_pkg for the entry type and depth
`default_nettype none

module jsu_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire jsu_pkg::seg_t wdata,
  input  wire logic          pop,
  output jsu_pkg::seg_t      rdata,
  output jsu_pkg::fifo_stat_t stat
);

  jsu_pkg::seg_t mem [jsu_pkg::QDepth];
  logic [jsu_pkg::QPtrW-1:0] wr_ptr, rd_ptr;
  logic [jsu_pkg::QCntW-1:0] count;

  assign rdata      = mem[rd_ptr];
  assign stat.full  = (count == jsu_pkg::QCntW'(jsu_pkg::QDepth));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + jsu_pkg::QPtrW'(1);
      if (pop)  rd_ptr <= rd_ptr + jsu_pkg::QPtrW'(1);
      if (push && !pop)      count <= count + jsu_pkg::QCntW'(1);
      else if (pop && !push) count <= count - jsu_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

endmodule

`default_nettype wire

// File: sv/jsu_back.sv
// back end: capacity check per sequence, byte serializer and output register
// uses jsu_pkg; takes sequences from jsu_fifo
`default_nettype none

module jsu_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [15:0]        out_capacity,
  input  wire jsu_pkg::seg_t      head,
  input  wire jsu_pkg::fifo_stat_t q_stat,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_byte,
  output logic                    out_last,
  output logic                    truncated
);

  logic [1:0]  idx;
  logic [15:0] bytes_written;
  logic        cut_flag;
  logic [15:0] limit;
  logic        fits, can_load, emit, drop;

  assign limit    = (out_capacity == 16'd0) ? 16'd0 : out_capacity - 16'd1;
  assign fits     = (bytes_written <= limit) &&
                    ((limit - bytes_written) >= {13'd0, head.len});
  assign can_load = !out_valid || !out_stall;

  always_comb begin
    q_pop = 1'b0;
    emit  = 1'b0;
    drop  = 1'b0;
    if (!q_stat.empty) begin
      if (head.term) begin
        emit  = can_load;
        q_pop = can_load;
      end else if (idx == 2'd0 && !fits) begin
        // whole sequence dropped, nothing goes out
        drop  = 1'b1;
        q_pop = 1'b1;
      end else if (can_load) begin
        emit  = 1'b1;
        q_pop = ({1'b0, idx} == head.len - 3'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      idx           <= 2'd0;
      bytes_written <= 16'd0;
      cut_flag      <= 1'b0;
    end else begin
      if (emit)            out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;

      if (emit && head.term) begin
        bytes_written <= 16'd0;
        cut_flag      <= 1'b0;
      end else if (emit) begin
        bytes_written <= bytes_written + 16'd1;
        idx           <= q_pop ? 2'd0 : idx + 2'd1;
      end else if (drop) begin
        cut_flag      <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte  <= head.term ? 8'd0 : head.data[idx];
      out_last  <= head.term;
      truncated <= head.term && cut_flag;
    end
  end

endmodule

`default_nettype wire

// File: sv/json_string_unescape_utf8_unit.sv
// json string unescaper with utf-8 output: top level, apb register, assertions
// an accepted byte is registered in the pending list, then the queue, then the output register
// throughput: one byte per cycle if it yields at most one queue entry and the queue has room;
//   a byte with more entries (the terminator counts as one) stalls the input until one is left
// back end sends one byte per cycle unless out_stall holds it; a dropped sequence sends nothing
// reset: synchronous, clears escape state, queue, counters; out_capacity returns to 65535
`default_nettype none

module json_string_unescape_utf8_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        body_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             out_last,
  output logic             truncated,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [15:0]         out_capacity;
  logic                q_push, q_pop;
  jsu_pkg::seg_t       q_wdata, q_head;
  jsu_pkg::fifo_stat_t q_stat;

  assign pready = 1'b1;
  assign prdata = (paddr == jsu_pkg::ADDR_CAP) ? {16'd0, out_capacity} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= jsu_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready) begin
      out_capacity <= pwdata[15:0];
    end
  end

  jsu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .body_end (body_end),
    .q_push   (q_push),
    .q_wdata  (q_wdata),
    .q_stat   (q_stat)
  );

  jsu_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_head),
    .stat  (q_stat)
  );

  jsu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .out_capacity (out_capacity),
    .head         (q_head),
    .q_stat       (q_stat),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .truncated    (truncated)
  );

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("sequence pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("sequence popped from an empty queue");

  a_term_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_last) |-> (out_byte == 8'd0))
    else $error("terminator transfer carries a nonzero byte");

  a_trunc_on_term: assert property (@(posedge clk) disable iff (rst)
    (out_valid && truncated) |-> out_last)
    else $error("truncated flag set on a data byte");
`endif

endmodule

`default_nettype wire
